/* rtl/core/bounded_deque_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the deque checker
// Clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define BDQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, disabled while reset is high
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

/* rtl/core/bdq_pkg.sv */
// ---------------------------------------------------------------------------
// Bounded deque package
// Request codes, field widths and the control bundle fed to every cell.
// ---------------------------------------------------------------------------
package bdq_pkg;

  localparam int FIELD_WIDTH       = 32;
  localparam int COUNT_FIELD_WIDTH = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Control broadcast to the cell row: request code and whether the
  // request changes the store in this cycle
  typedef struct packed {
    op_t  op;
    logic act;
  } cell_ctl_t;

endpackage

/* rtl/core/bdq_if.sv */
// ---------------------------------------------------------------------------
// Bounded deque channels
// Request and result channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface bdq_req_if import bdq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  op_t                    operation;
  logic [FIELD_WIDTH-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [FIELD_WIDTH-1:0]       popped_value;
  logic                         popped_valid;
  logic [FIELD_WIDTH-1:0]       front_value;
  logic                         is_empty;
  logic [COUNT_FIELD_WIDTH-1:0] entry_count;
  logic                         overflow;

  modport source (
    output valid, output popped_value, output popped_valid, output front_value,
    output is_empty, output entry_count, output overflow, input ready
  );
  modport sink (
    input valid, input popped_value, input popped_valid, input front_value,
    input is_empty, input entry_count, input overflow, output ready
  );
endinterface

/* rtl/core/bdq_cell.sv */
// ---------------------------------------------------------------------------
// Bounded deque cell
// One word slot of the shifting row; takes its neighbor's word on a push at
// the front or a pop at the front, and the pushed word at the tail slot.
// ---------------------------------------------------------------------------
module bdq_cell import bdq_pkg::*; #(
  parameter int WORD_WIDTH  = 32,
  parameter int COUNT_WIDTH = 5,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [WORD_WIDTH-1:0]  push_word,
  input  logic [WORD_WIDTH-1:0]  left_word,
  input  logic [WORD_WIDTH-1:0]  right_word,
  output logic [WORD_WIDTH-1:0]  word,
  output logic [WORD_WIDTH-1:0]  word_next,
  output logic [WORD_WIDTH-1:0]  tail_word
);

  // Select the word this slot holds after the request
  always_comb begin
    word_next = word;
    if (ctl.act) begin
      case (ctl.op)
        OP_PUSH_FRONT: word_next = left_word;
        OP_PUSH_BACK: begin
          if (count == COUNT_WIDTH'(INDEX)) word_next = push_word;
        end
        OP_POP_FRONT:  word_next = right_word;
        default:       word_next = word;
      endcase
    end
  end

  // Hold the slot word; contents are only read while live
  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // Offer the word when this slot is the last live one
  assign tail_word = (count == COUNT_WIDTH'(INDEX + 1)) ? word : '0;

endmodule

/* rtl/core/bounded_deque_unit.sv */
// ---------------------------------------------------------------------------
// Bounded deque unit
// Double-ended queue of up to DEPTH words kept in a row of shifting cells.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one request per transfer: push at the front, push at the
//   back, pop from the front or pop from the back, with the word to push.
//   rsp returns exactly one result per request: the popped word and its
//   flag, the front word after the request, the empty flag, the count and
//   the overflow flag for a push dropped on a full store.
// Latency: the result of a request is valid in the cycle after its transfer.
// Throughput: one request per cycle; the whole cell row and the count
//   update together, and the registered result stage lets a new
//   request in while the previous result is being taken.
// Stall: while a result waits and rsp.ready is low, req.ready is low and
//   the store holds; no request or result is lost.
// Reset: clears the count and the result stage and holds req.ready low; the
//   cell words keep whatever they held and are never read until written.
// A pop from an empty store changes nothing and reports popped_valid low.
// ---------------------------------------------------------------------------
module bounded_deque_unit import bdq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  bdq_req_if.sink   req,
  bdq_rsp_if.source rsp
);

  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   rsp_valid;

  logic                   transfer;
  logic                   is_push;
  logic                   full;
  logic                   empty;
  cell_ctl_t              ctl;

  logic [WORD_WIDTH-1:0]  push_word;
  logic [WORD_WIDTH-1:0]  cell_word [DEPTH];
  logic [WORD_WIDTH-1:0]  cell_tail [DEPTH];
  logic [WORD_WIDTH-1:0]  tail_acc  [DEPTH+1];
  logic [WORD_WIDTH-1:0]  front_next;
  logic [WORD_WIDTH-1:0]  popped_word;

  logic [FIELD_WIDTH-1:0]       popped_field;
  logic [FIELD_WIDTH-1:0]       front_field;
  logic [COUNT_FIELD_WIDTH-1:0] count_field;

  // Accept a request whenever the result stage is free or being drained
  assign req.ready = !rst && (!rsp_valid || rsp.ready);
  assign transfer  = req.valid && req.ready;

  // Decode the request
  assign is_push = (req.operation == OP_PUSH_FRONT) || (req.operation == OP_PUSH_BACK);
  assign full    = (count == COUNT_WIDTH'(DEPTH));
  assign empty   = (count == '0);
  assign ctl.op  = req.operation;
  assign ctl.act = transfer && (is_push ? !full : !empty);

  // Fit the pushed word to the storage width
  generate
    if (WORD_WIDTH > FIELD_WIDTH) begin : g_push_wide
      assign push_word = {{(WORD_WIDTH - FIELD_WIDTH){1'b0}}, req.push_value};
    end else begin : g_push_narrow
      assign push_word = req.push_value[WORD_WIDTH-1:0];
    end
  endgenerate

  // Build the cell row and the tail select chain
  assign tail_acc[0] = '0;
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word;
      logic [WORD_WIDTH-1:0] right_word;

      if (i == 0) begin : g_left_edge
        assign left_word = push_word;
      end else begin : g_left_inner
        assign left_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_right_edge
        assign right_word = '0;
      end else begin : g_right_inner
        assign right_word = cell_word[i+1];
      end

      if (i == 0) begin : g_head
        bdq_cell #(
          .WORD_WIDTH  (WORD_WIDTH),
          .COUNT_WIDTH (COUNT_WIDTH),
          .INDEX       (i)
        ) u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .count      (count),
          .push_word  (push_word),
          .left_word  (left_word),
          .right_word (right_word),
          .word       (cell_word[i]),
          .word_next  (front_next),
          .tail_word  (cell_tail[i])
        );
      end else begin : g_body
        bdq_cell #(
          .WORD_WIDTH  (WORD_WIDTH),
          .COUNT_WIDTH (COUNT_WIDTH),
          .INDEX       (i)
        ) u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .count      (count),
          .push_word  (push_word),
          .left_word  (left_word),
          .right_word (right_word),
          .word       (cell_word[i]),
          .word_next  (),
          .tail_word  (cell_tail[i])
        );
      end

      assign tail_acc[i+1] = tail_acc[i] | cell_tail[i];
    end
  endgenerate

  // Advance the count
  always_comb begin
    count_next = count;
    if (ctl.act) begin
      count_next = is_push ? count + COUNT_WIDTH'(1) : count - COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Pick the word leaving the store
  assign popped_word = (req.operation == OP_POP_FRONT) ? cell_word[0] : tail_acc[DEPTH];

  // Fit stored words and the count to the result fields
  generate
    if (WORD_WIDTH >= FIELD_WIDTH) begin : g_out_wide
      assign popped_field = popped_word[FIELD_WIDTH-1:0];
      assign front_field  = front_next[FIELD_WIDTH-1:0];
    end else begin : g_out_narrow
      assign popped_field = {{(FIELD_WIDTH - WORD_WIDTH){1'b0}}, popped_word};
      assign front_field  = {{(FIELD_WIDTH - WORD_WIDTH){1'b0}}, front_next};
    end

    if (COUNT_WIDTH >= COUNT_FIELD_WIDTH) begin : g_cnt_wide
      assign count_field = count_next[COUNT_FIELD_WIDTH-1:0];
    end else begin : g_cnt_narrow
      assign count_field = {{(COUNT_FIELD_WIDTH - COUNT_WIDTH){1'b0}}, count_next};
    end
  endgenerate

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (transfer) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (transfer) begin
      rsp.popped_value <= (!is_push && !empty) ? popped_field : '0;
      rsp.popped_valid <= !is_push && !empty;
      rsp.front_value  <= (count_next != '0) ? front_field : '0;
      rsp.is_empty     <= (count_next == '0);
      rsp.entry_count  <= count_field;
      rsp.overflow     <= is_push && full;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

/* rtl/core/bdq_checker.sv */
// ---------------------------------------------------------------------------
// Bounded deque checker
// Port-level checks on result consistency and the result handshake.
// ---------------------------------------------------------------------------
`include "bounded_deque_unit_macros.svh"

module bdq_checker import bdq_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [FIELD_WIDTH-1:0]       popped_value,
  input logic                         popped_valid,
  input logic [FIELD_WIDTH-1:0]       front_value,
  input logic                         is_empty,
  input logic [COUNT_FIELD_WIDTH-1:0] entry_count,
  input logic                         overflow
);

  // A stalled result keeps its fields
  `BDQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(popped_value) && $stable(front_value) && $stable(entry_count))

  // An empty store reports no count and no front word
  `BDQ_ASSERT_IMPLY(a_empty_fields, clk, rst, rsp_valid && is_empty, entry_count == '0 && front_value == '0)

  // A dropped push never pops and leaves a non-empty store
  `BDQ_ASSERT_IMPLY(a_overflow_excl, clk, rst, rsp_valid && overflow, !popped_valid && !is_empty)

  // A request that popped nothing reports a zero word
  `BDQ_ASSERT_IMPLY(a_pop_zero, clk, rst, rsp_valid && !popped_valid, popped_value == '0)

  // No result is shown right after reset
  `BDQ_ASSERT_IMPLY(a_reset_clear, clk, rst, $past(rst), !rsp_valid)

endmodule

bind bounded_deque_unit bdq_checker u_bdq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .popped_value (rsp.popped_value),
  .popped_valid (rsp.popped_valid),
  .front_value  (rsp.front_value),
  .is_empty     (rsp.is_empty),
  .entry_count  (rsp.entry_count),
  .overflow     (rsp.overflow)
);

/* test/tb_bounded_deque_unit.sv */
// ---------------------------------------------------------------------------
// Bounded deque unit testbench
// Drives push/pop requests at both ends through the request channel and
// checks every result against a ring-buffer prediction, or a typed row's
// fixed result. A short directed table covers the empty store, full-store
// drops and extreme words. Random traffic then sweeps between fill-heavy
// and drain-heavy stretches, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module tb_bounded_deque_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int STORE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 1880;
  localparam int QUIET_TAIL   = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_WAIT  = 4;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0]       popped_value;
    logic                         popped_valid;
    logic [FIELD_WIDTH-1:0]       front_value;
    logic                         is_empty;
    logic [COUNT_FIELD_WIDTH-1:0] entry_count;
    logic                         overflow;
  } deque_result_t;

  typedef struct {
    op_t                    op;
    logic [FIELD_WIDTH-1:0] value;
    int                     reps;
    bit                     typed;
    deque_result_t          known;
  } directed_row_t;

  typedef struct {
    bit            typed;
    deque_result_t known;
  } request_note_t;

  logic clk = 1'b0;
  logic rst;

  bdq_req_if req_ch ();
  bdq_rsp_if rsp_ch ();

  bounded_deque_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the deque: ring of words, front position and live count
  logic [FIELD_WIDTH-1:0] ring_words [STORE_DEPTH];
  logic [3:0]             head_pos = '0;
  logic [4:0]             live_count = '0;

  deque_result_t   expected_results [$];
  request_note_t   request_notes [$];
  directed_row_t   directed_rows [$];

  int  error_count = 0;
  int  requests_taken = 0;
  int  results_seen = 0;
  int  full_drops = 0;
  int  empty_pops = 0;
  int  times_full = 0;
  int  times_emptied = 0;
  bit  calm_stretch = 1'b0;
  bit  quiet_tail = 1'b0;

  // Apply one request to the shadow deque and return its result
  function automatic deque_result_t apply_request(op_t op, logic [FIELD_WIDTH-1:0] word);
    deque_result_t r;
    r = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (live_count >= 5'(STORE_DEPTH)) begin
          r.overflow = 1'b1;
          full_drops++;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_pos = head_pos - 4'd1;
            ring_words[head_pos] = word;
          end else begin
            ring_words[head_pos + live_count[3:0]] = word;
          end
          live_count = live_count + 5'd1;
          if (live_count == 5'(STORE_DEPTH)) times_full++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (live_count == '0) begin
          empty_pops++;
        end else begin
          if (op == OP_POP_FRONT) begin
            r.popped_value = ring_words[head_pos];
            head_pos = head_pos + 4'd1;
          end else begin
            r.popped_value = ring_words[head_pos + live_count[3:0] - 4'd1];
          end
          r.popped_valid = 1'b1;
          live_count = live_count - 5'd1;
          if (live_count == '0) times_emptied++;
        end
      end
      default: ;
    endcase
    r.front_value = (live_count != '0) ? ring_words[head_pos] : '0;
    r.is_empty    = (live_count == '0);
    r.entry_count = live_count;
    return r;
  endfunction

  // Check the result transfer first, then log the new request transfer
  always @(posedge clk) begin : scoreboard
    deque_result_t got;
    deque_result_t want;
    deque_result_t model;
    request_note_t note;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.popped_value, rsp_ch.popped_valid, rsp_ch.front_value,
                rsp_ch.is_empty, rsp_ch.entry_count, rsp_ch.overflow};
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.popped_value !== want.popped_value) begin
            $error("popped_value: expected %h, got %h", want.popped_value, got.popped_value);
            error_count++;
          end
          if (got.popped_valid !== want.popped_valid) begin
            $error("popped_valid: expected %b, got %b", want.popped_valid, got.popped_valid);
            error_count++;
          end
          if (got.front_value !== want.front_value) begin
            $error("front_value: expected %h, got %h", want.front_value, got.front_value);
            error_count++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
            error_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            error_count++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, got.overflow);
            error_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        note = request_notes.pop_front();
        model = apply_request(req_ch.operation, req_ch.push_value);
        expected_results.push_back(note.typed ? note.known : model);
        requests_taken++;
      end
    end
  end

  // Result side: random stall bursts, none in calm stretches or the tail
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!rst && !quiet_tail && !calm_stretch && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Hold a request until its transfer, then return on the next falling edge
  task automatic send_request(op_t op, logic [FIELD_WIDTH-1:0] word, bit typed,
                              deque_result_t known);
    request_notes.push_back('{typed, known});
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.push_value <= word;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic void add_row(op_t op, logic [FIELD_WIDTH-1:0] word, int reps, bit typed,
                                  deque_result_t known);
    directed_rows.push_back('{op, word, reps, typed, known});
  endfunction

  initial begin : stimulus
    op_t                    op;
    logic [FIELD_WIDTH-1:0] word;
    int                     seg_left;
    int                     push_pct;
    int                     gap;
    rst = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_PUSH_FRONT;
    req_ch.push_value = '0;

    // Empty store pops, extreme words, fill to the brim, drop on full
    add_row(OP_POP_FRONT,  32'h0000_0000, 1, 1'b1, '{'0, 1'b0, '0, 1'b1, 5'd0, 1'b0});
    add_row(OP_POP_BACK,   32'hFFFF_FFFF, 1, 1'b1, '{'0, 1'b0, '0, 1'b1, 5'd0, 1'b0});
    add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b1,
            '{'0, 1'b0, 32'hFFFF_FFFF, 1'b0, 5'd1, 1'b0});
    add_row(OP_PUSH_BACK,  32'h0000_0000, 1, 1'b0, '0);
    add_row(OP_POP_BACK,   32'h1234_5678, 1, 1'b0, '0);
    add_row(OP_POP_FRONT,  32'h0000_0000, 1, 1'b1,
            '{32'hFFFF_FFFF, 1'b1, '0, 1'b1, 5'd0, 1'b0});
    add_row(OP_PUSH_FRONT, 32'h8000_0000, 8, 1'b0, '0);
    add_row(OP_PUSH_BACK,  32'h0000_0001, 8, 1'b0, '0);
    add_row(OP_PUSH_FRONT, 32'hDEAD_BEEF, 1, 1'b1,
            '{'0, 1'b0, 32'h8000_0007, 1'b0, 5'd16, 1'b1});
    add_row(OP_PUSH_BACK,  32'hFFFF_FFFF, 1, 1'b1,
            '{'0, 1'b0, 32'h8000_0007, 1'b0, 5'd16, 1'b1});
    add_row(OP_POP_BACK,   32'h0000_0000, 1, 1'b0, '0);
    add_row(OP_POP_FRONT,  32'h0000_0000, 1, 1'b0, '0);

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table back to back
    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++) begin
        send_request(directed_rows[i].op, directed_rows[i].value + r,
                     directed_rows[i].typed, directed_rows[i].known);
      end
    end

    // Random traffic in stretches that lean toward filling or draining
    seg_left = 0;
    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        case ($urandom_range(0, 3))
          0:       push_pct = 15;
          1:       push_pct = 50;
          2:       push_pct = 85;
          default: push_pct = 97;
        endcase
        calm_stretch = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      if (n >= RANDOM_ITEMS - QUIET_TAIL) quiet_tail = 1'b1;

      // Hold off once until the store has answered everything
      if (n == RANDOM_ITEMS / 2) drain_results();

      if ($urandom_range(1, 100) <= push_pct)
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      case ($urandom_range(0, 7))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase

      if (!quiet_tail && !calm_stretch && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      send_request(op, word, 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE_WAIT) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end

    $display("tb: %0d requests, %0d results; store filled %0d times, emptied %0d times",
             requests_taken, results_seen, times_full, times_emptied);
    $display("tb: %0d pushes dropped on a full store, %0d pops on an empty store",
             full_drops, empty_pops);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bdq_pkg.sv
rtl/core/bdq_if.sv
rtl/core/bdq_cell.sv
rtl/core/bounded_deque_unit.sv
rtl/core/bdq_checker.sv
test/tb_bounded_deque_unit.sv
